// ===== rtl/spk_pkg.sv =====
// Shared constants, types and round functions of the Speck-128/256 cipher block.
package spk_pkg;

  localparam int ROUNDS    = 34;
  localparam int WORD_BITS = 64;
  localparam int ROT_A     = 8;
  localparam int ROT_B     = 3;
  localparam int KEY_WORDS = 4;

  localparam int CNT_W = $clog2(ROUNDS);
  localparam int IDX_W = $clog2(KEY_WORDS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic {
    KIND_ENCRYPT = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    kind_t kind;
    word_t x;
    word_t y;
  } stage_t;

  function automatic word_t rotr(word_t v, int r);
    return (v >> r) | (v << (WORD_BITS - r));
  endfunction

  function automatic word_t rotl(word_t v, int r);
    return (v << r) | (v >> (WORD_BITS - r));
  endfunction

  // One round in either direction; the caller supplies the matching round key.
  function automatic stage_t do_round(stage_t s, word_t k_enc, word_t k_dec);
    stage_t o;
    word_t  nx;
    word_t  ny;
    o.kind = s.kind;
    if (s.kind == KIND_DECRYPT) begin
      ny = rotr(s.x ^ s.y, ROT_B);
      nx = rotl((s.x ^ k_dec) - ny, ROT_A);
    end else begin
      nx = (rotr(s.x, ROT_A) + s.y) ^ k_enc;
      ny = rotl(s.y, ROT_B) ^ nx;
    end
    o.x = nx;
    o.y = ny;
    return o;
  endfunction

endpackage

// ===== rtl/spk_ifs.sv =====
// Handshake channel interfaces for block requests, results and key writes.
interface spk_blk_if import spk_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t block_high;
  word_t block_low;

  modport source (output valid, kind, block_high, block_low, input ready);
  modport sink   (input valid, kind, block_high, block_low, output ready);
endinterface

interface spk_res_if import spk_pkg::*;;
  logic  valid;
  logic  ready;
  word_t result_high;
  word_t result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface spk_cfg_if import spk_pkg::*;;
  logic  valid;
  logic  ready;
  idx_t  index;
  word_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/speck_block_cipher_top.sv =====
// One round per pipeline stage.
// Throughput: one request per cycle while no key schedule runs; stages close up bubbles,
// so a stalled result does not block entry while earlier stages still have room.
// Reset clears the key to zero and runs the key schedule; this and every key write
// keep requests out while the round keys are rebuilt one per cycle.
module speck_block_cipher_top import spk_pkg::*; (
  input logic        clk,
  input logic        rst,
  spk_blk_if.sink    blk,
  spk_res_if.source  res,
  spk_cfg_if.sink    cfg
);

  word_t  key_word [KEY_WORDS];
  word_t  rk [ROUNDS];
  word_t  k_cur;
  word_t  l_sched [KEY_WORDS-1];
  cnt_t   cnt;
  logic   load;
  logic   busy;
  word_t  l_next;
  word_t  k_next;

  stage_t stg [ROUNDS];
  logic   stg_v [ROUNDS];
  logic   stg_vin [ROUNDS];
  logic   stg_rdy [ROUNDS+1];
  stage_t stg_next [ROUNDS];
  stage_t in_stage;
  logic   in_fire;

  assign cfg.ready = 1'b1;

  // Key schedule: one step of the expansion per cycle.
  always_comb begin
    l_next = (k_cur + rotr(l_sched[0], ROT_A)) ^ {{(WORD_BITS-CNT_W){1'b0}}, cnt};
    k_next = rotl(k_cur, ROT_B) ^ l_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
      load <= 1'b1;
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        key_word[cfg.index] <= cfg.data;
        load <= 1'b1;
        busy <= 1'b0;
      end else if (load) begin
        load <= 1'b0;
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + cnt_t'(1);
        if (cnt == cnt_t'(ROUNDS - 2)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      k_cur <= key_word[KEY_WORD_0];
      rk[0] <= key_word[KEY_WORD_0];
      for (int i = 0; i < KEY_WORDS - 1; i++) begin
        l_sched[i] <= key_word[i+1];
      end
    end else if (busy) begin
      k_cur <= k_next;
      for (int i = 0; i < KEY_WORDS - 2; i++) begin
        l_sched[i] <= l_sched[i+1];
      end
      l_sched[KEY_WORDS-2] <= l_next;
      for (int j = 1; j < ROUNDS; j++) begin
        if (cnt == cnt_t'(j - 1)) begin
          rk[j] <= k_next;
        end
      end
    end
  end

  // Round pipeline: a stage takes new data whenever it is empty or its successor moves.
  assign stg_rdy[ROUNDS] = res.ready;
  assign blk.ready = stg_rdy[0] && !busy && !load;
  assign in_fire   = blk.valid && blk.ready;

  always_comb begin
    in_stage.kind = blk.kind;
    in_stage.x    = blk.block_high;
    in_stage.y    = blk.block_low;
  end

  for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
    assign stg_rdy[s] = !stg_v[s] || stg_rdy[s+1];

    if (s == 0) begin : g_first
      assign stg_next[s] = do_round(in_stage, rk[s], rk[ROUNDS-1-s]);
      assign stg_vin[s]  = in_fire;
    end else begin : g_rest
      assign stg_next[s] = do_round(stg[s-1], rk[s], rk[ROUNDS-1-s]);
      assign stg_vin[s]  = stg_v[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_v[s] <= 1'b0;
      end else if (stg_rdy[s]) begin
        stg_v[s] <= stg_vin[s];
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[s]) begin
        stg[s] <= stg_next[s];
      end
    end
  end

  assign res.valid       = stg_v[ROUNDS-1];
  assign res.result_high = stg[ROUNDS-1].x;
  assign res.result_low  = stg[ROUNDS-1].y;

  // A key write must shut out requests until the schedule has been rebuilt.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> !blk.ready)
    else $error("request accepted right after a key write");

  // The schedule ends after its last step.
  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    busy && !(cfg.valid && cfg.ready) && cnt == cnt_t'(ROUNDS - 2) |=> !busy && !load)
    else $error("key schedule ran past its last step");

  // A full pipeline with a stalled result has no room for a request.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    stg_v[0] && stg_v[ROUNDS/2] && stg_rdy[1] == 1'b0 |-> !blk.ready)
    else $error("request accepted into an occupied first stage");

  // A held result keeps its value until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.result_high)
      && $stable(res.result_low))
    else $error("result changed while stalled");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the Speck-128/256 block cipher under random flow control.
module tb import spk_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 2 * ROUNDS + 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BLOCKS  = 250;

  typedef struct {
    kind_t kind;
    word_t hi;
    word_t lo;
  } block_req_t;

  typedef struct {
    word_t hi;
    word_t lo;
  } block_pair_t;

  logic clk;
  logic rst;

  spk_blk_if blk_ch ();
  spk_res_if res_ch ();
  spk_cfg_if cfg_ch ();

  speck_block_cipher_top u_dut (
    .clk (clk),
    .rst (rst),
    .blk (blk_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  word_t       key_reg [KEY_WORDS];
  word_t       round_key [ROUNDS];
  block_req_t  pending_q [$];
  block_pair_t cipher_q [$];

  int mismatches  = 0;
  int encrypts    = 0;
  int decrypts    = 0;
  int key_writes  = 0;
  int key_sets    = 0;
  int send_gap    = 0;
  int recv_stall  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;
  bit blk_fire    = 1'b0;
  bit res_fire    = 1'b0;
  bit cfg_fire    = 1'b0;

  function automatic word_t spin_right(word_t v, int n);
    return (v >> n) | (v << (WORD_BITS - n));
  endfunction

  function automatic word_t spin_left(word_t v, int n);
    return (v << n) | (v >> (WORD_BITS - n));
  endfunction

  function automatic void expand_round_keys();
    word_t sched [ROUNDS + KEY_WORDS];
    round_key[0] = key_reg[KEY_WORD_0];
    sched[0] = key_reg[KEY_WORD_1];
    sched[1] = key_reg[KEY_WORD_2];
    sched[2] = key_reg[KEY_WORD_3];
    for (int i = 0; i < ROUNDS - 1; i++) begin
      sched[i + KEY_WORDS - 1] = (round_key[i] + spin_right(sched[i], ROT_A)) ^ word_t'(i);
      round_key[i + 1] = spin_left(round_key[i], ROT_B) ^ sched[i + KEY_WORDS - 1];
    end
  endfunction

  function automatic block_pair_t run_cipher(block_req_t b);
    block_pair_t r;
    word_t       x;
    word_t       y;
    x = b.hi;
    y = b.lo;
    if (b.kind == KIND_ENCRYPT) begin
      for (int i = 0; i < ROUNDS; i++) begin
        x = (spin_right(x, ROT_A) + y) ^ round_key[i];
        y = spin_left(y, ROT_B) ^ x;
      end
    end else begin
      // Decryption walks the round keys backwards, undoing each round in turn.
      for (int i = ROUNDS - 1; i >= 0; i--) begin
        y = spin_right(x ^ y, ROT_B);
        x = spin_left((x ^ round_key[i]) - y, ROT_A);
      end
    end
    r.hi = x;
    r.lo = y;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_BITS - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic kind_t rand_kind();
    return $urandom_range(0, 1) ? KIND_DECRYPT : KIND_ENCRYPT;
  endfunction

  function automatic void queue_block(kind_t k, word_t hi, word_t lo);
    block_req_t b;
    b.kind = k;
    b.hi   = hi;
    b.lo   = lo;
    pending_q = {pending_q, b};
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic write_key(cfg_idx_t ix, word_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ix;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    key_reg[ix] = value;
    expand_round_keys();
    key_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all_keys(word_t w0, word_t w1, word_t w2, word_t w3);
    write_key(KEY_WORD_0, w0);
    write_key(KEY_WORD_1, w1);
    write_key(KEY_WORD_2, w2);
    write_key(KEY_WORD_3, w3);
    key_sets++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || blk_ch.valid || cipher_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: holds a request until it is taken, then waits out a random gap.
  always @(negedge clk) begin
    block_req_t req;
    if (rst) begin
      blk_ch.valid <= 1'b0;
    end else if (!blk_ch.valid || blk_fire) begin
      if (send_gap > 0) begin
        blk_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_q.size() != 0) begin
        req = pending_q.pop_front();
        blk_ch.valid      <= 1'b1;
        blk_ch.kind       <= req.kind;
        blk_ch.block_high <= req.hi;
        blk_ch.block_low  <= req.lo;
        send_gap = pick_gap();
      end else begin
        blk_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      res_ch.ready <= 1'b0;
      recv_stall--;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
    end
  end

  // Monitor: predicts each accepted request and checks each accepted result in order.
  always @(posedge clk) begin
    block_req_t  b;
    block_pair_t want;
    blk_fire = !rst && blk_ch.valid && blk_ch.ready;
    res_fire = !rst && res_ch.valid && res_ch.ready;
    cfg_fire = !rst && cfg_ch.valid && cfg_ch.ready;
    if (res_fire) begin
      if (cipher_q.size() == 0) begin
        note_error($sformatf("unexpected result %h %h", res_ch.result_high,
                             res_ch.result_low));
      end else begin
        want = cipher_q.pop_front();
        if (res_ch.result_high !== want.hi || res_ch.result_low !== want.lo)
          note_error($sformatf("result mismatch: expected %h %h, got %h %h", want.hi,
                               want.lo, res_ch.result_high, res_ch.result_low));
      end
    end
    if (blk_fire) begin
      b.kind = blk_ch.kind;
      b.hi   = blk_ch.block_high;
      b.lo   = blk_ch.block_low;
      cipher_q = {cipher_q, run_cipher(b)};
      if (b.kind == KIND_ENCRYPT) encrypts++;
      else decrypts++;
    end
    if (rst || blk_fire || res_fire || cfg_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, cipher_q.size());
        $display("[speck_block_cipher_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    block_req_t  b;
    block_pair_t c;
    rst               = 1'b1;
    blk_ch.valid      = 1'b0;
    blk_ch.kind       = KIND_ENCRYPT;
    blk_ch.block_high = '0;
    blk_ch.block_low  = '0;
    res_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = KEY_WORD_0;
    cfg_ch.data       = '0;
    foreach (key_reg[i]) key_reg[i] = '0;
    expand_round_keys();
    key_sets = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The all-zero key left by reset, with extreme blocks in both directions.
    queue_block(KIND_ENCRYPT, '0, '0);
    queue_block(KIND_DECRYPT, '0, '0);
    queue_block(KIND_ENCRYPT, '1, '1);
    queue_block(KIND_DECRYPT, '1, '1);
    wait_idle();

    // Published test vector, then edge patterns under the same key.
    write_all_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    queue_block(KIND_ENCRYPT, 64'h65736f6874206e49, 64'h202e72656e6f6f70);
    queue_block(KIND_DECRYPT, 64'h4109010405c0f53e, 64'h4eeeb48d9c188f43);
    queue_block(KIND_ENCRYPT, 64'h8000000000000000, '0);
    queue_block(KIND_DECRYPT, '0, 64'h0000000000000001);
    queue_block(KIND_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    queue_block(KIND_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    queue_block(KIND_ENCRYPT, '1, '0);
    queue_block(KIND_DECRYPT, '0, '1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p % 3 == 2);
      case (p)
        0: begin
          write_all_keys('1, '1, '1, '1);
        end
        1: begin
          write_all_keys('0, '0, '0, '0);
        end
        default: begin
          if (p % 2 == 0) begin
            write_key(cfg_idx_t'($urandom_range(0, KEY_WORDS - 1)), rand_word());
            key_sets++;
          end else begin
            write_all_keys(rand_word(), rand_word(), rand_word(), rand_word());
          end
        end
      endcase
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        b.kind = rand_kind();
        b.hi   = rand_word();
        b.lo   = rand_word();
        pending_q = {pending_q, b};
        // Often follow a block with the opposite operation on its own output.
        if ($urandom_range(0, 3) == 0) begin
          c = run_cipher(b);
          queue_block(b.kind == KIND_ENCRYPT ? KIND_DECRYPT : KIND_ENCRYPT, c.hi, c.lo);
          n++;
        end
      end
      wait_idle();
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d blocks (%0d encrypt, %0d decrypt) across %0d keys, %0d key writes.",
             encrypts + decrypts, encrypts, decrypts, key_sets, key_writes);
    $display("Random request gaps and result stalls mixed with stall-free runs; %0d failures.",
             mismatches + cipher_q.size());
    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("[speck_block_cipher_top] OK");
    end else begin
      $display("[speck_block_cipher_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spk_pkg.sv
rtl/spk_ifs.sv
rtl/speck_block_cipher_top.sv
tb/tb.sv
